@@ design/i2cm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

   // command codes, also the running operation
   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } i2cm_op_type;

   localparam logic [7:0]  MSB_MASK     = 8'b1000_0000;
   localparam logic [5:0]  BYTE_BITS    = 6'd8;
   localparam logic [15:0] DELAY_RESET  = 16'd5;

   // phase numbers inside a start, stop, write or read sequence
   localparam logic [5:0] PH_FIRST     = 6'd0;
   localparam logic [5:0] PH_DATA_END  = 6'd2 * BYTE_BITS;
   localparam logic [5:0] PH_ACK_HIGH  = PH_DATA_END + 6'd1;
   localparam logic [5:0] PH_ACK_LOW   = PH_DATA_END + 6'd2;
   localparam logic [5:0] PH_STOP_SCL  = 6'd1;
   localparam logic [5:0] PH_STOP_SDA  = 6'd2;

   // sequence lengths in phases
   localparam logic [5:0] LEN_START = 6'd2;
   localparam logic [5:0] LEN_STOP  = 6'd3;
   localparam logic [5:0] LEN_BYTE  = PH_DATA_END + 6'd4;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       sda_in;
   } i2cm_item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       acked;
   } i2cm_result_type;

   typedef struct packed {
      i2cm_op_type op;
      logic [5:0]  phase;
      logic [7:0]  shift;
      logic [15:0] delay;
      logic        scl;
      logic        sda;
      logic        dir;
      logic        ack;
      logic        send_ack;
      logic [7:0]  rx_hold;
   } i2cm_state_type;

   function automatic logic [5:0] seq_len(input i2cm_op_type op);
      case (op)
         OP_START: seq_len = LEN_START;
         OP_STOP:  seq_len = LEN_STOP;
         default:  seq_len = LEN_BYTE;
      endcase
   endfunction

   // pin action for phase p of the running operation
   function automatic i2cm_state_type do_action(input i2cm_state_type s,
                                                input logic [5:0] p,
                                                input logic sda_in);
      i2cm_state_type r;
      r = s;
      case (s.op)
         OP_START: begin
            if (p == PH_FIRST) r.sda = 1'b0;
            else r.scl = 1'b0;
         end
         OP_STOP: begin
            if (p == PH_STOP_SCL) r.scl = 1'b1;
            else if (p == PH_STOP_SDA) r.sda = 1'b1;
         end
         OP_WRITE: begin
            if (p == PH_FIRST) begin
               r.sda = |(s.shift & MSB_MASK);
            end else if (p < PH_DATA_END && p[0]) begin
               r.scl = 1'b1;
            end else if (p <= PH_DATA_END) begin
               r.scl   = 1'b0;
               r.shift = {s.shift[6:0], 1'b0};
               if (p < PH_DATA_END) begin
                  r.sda = s.shift[6];
               end else begin
                  r.sda = 1'b1;
                  r.dir = 1'b0;
               end
            end else if (p == PH_ACK_HIGH) begin
               r.scl = 1'b1;
               r.ack = ~sda_in;
            end else if (p == PH_ACK_LOW) begin
               r.dir = 1'b1;
               r.scl = 1'b0;
               r.sda = 1'b1;
            end else begin
               r.sda = 1'b0;
            end
         end
         OP_READ: begin
            if (p == PH_FIRST) begin
               r.dir = 1'b0;
            end else if (p < PH_DATA_END && p[0]) begin
               r.scl   = 1'b1;
               r.shift = {s.shift[6:0], sda_in};
            end else if (p <= PH_DATA_END) begin
               r.scl = 1'b0;
               if (p == PH_DATA_END) begin
                  r.dir = 1'b1;
                  r.sda = ~s.send_ack;
               end
            end else if (p == PH_ACK_HIGH) begin
               r.scl = 1'b1;
            end else if (p == PH_ACK_LOW) begin
               r.scl = 1'b0;
               r.sda = 1'b1;
            end else begin
               r.sda = 1'b0;
            end
         end
         default: r = s;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/i2cm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// command and tick channel
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] tx_byte;
   logic       ack_to_send;
   logic       sda_in;

   modport source (output valid, mode, tx_byte, ack_to_send, sda_in, input ready);
   modport sink   (input valid, mode, tx_byte, ack_to_send, sda_in, output ready);
endinterface

// pin and status channel
interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       acked;

   modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                   rx_byte, acked, input ready);
   modport sink   (input valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                   rx_byte, acked, output ready);
endinterface

`default_nettype wire

@@ design/i2c_master_bit_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake     contents
// req_ch   in   valid/ready   mode, tx_byte, ack_to_send, sda_in
// rsp_ch   out  valid/ready   scl_out, sda_out, sda_drive, busy_res, done_res,
//                             rx_byte, acked
// csr      in   csr_wr_en     csr_wr_data = delay_ticks
//
// one item per clock while the result is not stalled; an item is held in the input
// register and its result is then registered in the result register
// the sequencer state steps once per item as it leaves the input register
// synchronous reset clears control state, delay_ticks returns to 5
// a stalled result holds both registers; the input side keeps taking items
// while either register is free

module i2c_master_bit_engine
   import i2cm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   i2cm_req_if.sink     req_ch,
   i2cm_rsp_if.source   rsp_ch,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic            in_valid_ff, in_valid_in;
   i2cm_item_type   in_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   i2cm_result_type rsp_res_ff;
   i2cm_result_type result_in;
   logic [15:0]     delay_ticks_ff;
   logic            out_free;
   logic            advance;
   logic            req_take;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ticks_ff <= DELAY_RESET;
      end else if (csr_wr_en) begin
         delay_ticks_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_item_ff <= '{mode: req_ch.mode, tx_byte: req_ch.tx_byte,
                         ack_to_send: req_ch.ack_to_send, sda_in: req_ch.sda_in};
      end
   end

   i2cm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .item        (in_item_ff),
      .delay_ticks (delay_ticks_ff),
      .result_in   (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_res_ff <= result_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.scl_out   = rsp_res_ff.scl_out;
   assign rsp_ch.sda_out   = rsp_res_ff.sda_out;
   assign rsp_ch.sda_drive = rsp_res_ff.sda_drive;
   assign rsp_ch.busy_res  = rsp_res_ff.busy_res;
   assign rsp_ch.done_res  = rsp_res_ff.done_res;
   assign rsp_ch.rx_byte   = rsp_res_ff.rx_byte;
   assign rsp_ch.acked     = rsp_res_ff.acked;

endmodule

`default_nettype wire

@@ design/i2cm_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core
   import i2cm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire i2cm_item_type   item,
   input  wire logic [15:0]     delay_ticks,
   output i2cm_result_type      result_in
);

   i2cm_state_type state_ff, state_in;
   logic           done;
   logic [15:0]    delay_load;
   logic [15:0]    delay_dec;
   logic [5:0]     phase_nxt;

   assign delay_load = (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
   assign delay_dec  = (state_ff.delay != 16'd0) ? state_ff.delay - 16'd1 : 16'd0;
   assign phase_nxt  = state_ff.phase + 6'd1;

   // one item worth of sequencing
   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      if (state_ff.op == OP_IDLE) begin
         if (item.mode inside {[OP_START:OP_READ]}) begin
            state_in.op    = i2cm_op_type'(item.mode);
            state_in.phase = PH_FIRST;
            if (item.mode == OP_WRITE) state_in.shift = item.tx_byte;
            if (item.mode == OP_READ) begin
               state_in.shift    = 8'd0;
               state_in.send_ack = item.ack_to_send;
            end
            state_in       = do_action(state_in, PH_FIRST, item.sda_in);
            state_in.delay = delay_load;
         end
      end else begin
         state_in.delay = delay_dec;
         if (delay_dec == 16'd0) begin
            state_in.phase = phase_nxt;
            if (phase_nxt >= seq_len(state_ff.op)) begin
               done = 1'b1;
            end else begin
               state_in = do_action(state_in, phase_nxt, item.sda_in);
               if (state_ff.op == OP_STOP && phase_nxt == PH_STOP_SDA) done = 1'b1;
               else state_in.delay = delay_load;
            end
            // sequence end: back to idle, keep a finished read
            if (done) begin
               if (state_ff.op == OP_READ) state_in.rx_hold = state_in.shift;
               state_in.op    = OP_IDLE;
               state_in.phase = 6'd0;
               state_in.delay = 16'd0;
            end
         end
      end
   end

   // state after this item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.op       <= OP_IDLE;
         state_ff.phase    <= 6'd0;
         state_ff.shift    <= 8'd0;
         state_ff.delay    <= 16'd0;
         state_ff.scl      <= 1'b1;
         state_ff.sda      <= 1'b1;
         state_ff.dir      <= 1'b1;
         state_ff.ack      <= 1'b0;
         state_ff.send_ack <= 1'b0;
         state_ff.rx_hold  <= 8'd0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   // released sda while it is an input
   always_comb begin
      result_in.scl_out   = state_in.scl;
      result_in.sda_out   = state_in.dir ? state_in.sda : 1'b1;
      result_in.sda_drive = state_in.dir;
      result_in.busy_res  = (state_in.op != OP_IDLE);
      result_in.done_res  = done;
      result_in.rx_byte   = state_in.rx_hold;
      result_in.acked     = state_in.ack;
   end

endmodule

`default_nettype wire

@@ design/i2cm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       scl_out,
   input wire logic       sda_out,
   input wire logic       sda_drive,
   input wire logic       busy_res,
   input wire logic       done_res,
   input wire logic [7:0] rx_byte,
   input wire logic       acked
);

   // a stalled result holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({scl_out, sda_out, sda_drive,
                                   busy_res, done_res, rx_byte, acked}))
      else $error("stalled result changed");

   // a finishing item leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res)
      else $error("done with busy still set");

   // sda released while it is an input
   a_sda_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !sda_drive |-> sda_out)
      else $error("sda driven low while input");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input accepted whenever the result side is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .scl_out   (rsp_ch.scl_out),
   .sda_out   (rsp_ch.sda_out),
   .sda_drive (rsp_ch.sda_drive),
   .busy_res  (rsp_ch.busy_res),
   .done_res  (rsp_ch.done_res),
   .rx_byte   (rsp_ch.rx_byte),
   .acked     (rsp_ch.acked)
);

`default_nettype wire
